@@ src/crs_pkg.sv @@
// Shared constants, job sizing and the t step table for the Catmull-Rom sampler.
package crs_pkg;

	localparam int COORD_WIDTH   = 24;
	localparam int CFG_W         = 5;
	localparam int MAX_SAMPLES   = 31;
	localparam int SAMPLES_MIN   = 2;
	localparam int SAMPLES_RESET = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int FRAC_EXTRA    = 8;
	localparam int T_FRAC        = 16;
	localparam int T_W           = 16;

	// One queued job: coefficients d, c, b, a for both axes, sample count, last flag.
	function automatic int job_width(input int cw);
		return 2 * (4 * cw + 9) + CFG_W + 1;
	endfunction

	// round(65536 / s), the t increment for s samples per segment
	function automatic logic [T_W-1:0] recip(input logic [CFG_W-1:0] s);
		logic [T_W-1:0] r;
		case (s)
			5'd2:    r = 16'd32768;
			5'd3:    r = 16'd21845;
			5'd4:    r = 16'd16384;
			5'd5:    r = 16'd13107;
			5'd6:    r = 16'd10923;
			5'd7:    r = 16'd9362;
			5'd8:    r = 16'd8192;
			5'd9:    r = 16'd7282;
			5'd10:   r = 16'd6554;
			5'd11:   r = 16'd5958;
			5'd12:   r = 16'd5461;
			5'd13:   r = 16'd5041;
			5'd14:   r = 16'd4681;
			5'd15:   r = 16'd4369;
			5'd16:   r = 16'd4096;
			5'd17:   r = 16'd3855;
			5'd18:   r = 16'd3641;
			5'd19:   r = 16'd3449;
			5'd20:   r = 16'd3277;
			5'd21:   r = 16'd3121;
			5'd22:   r = 16'd2979;
			5'd23:   r = 16'd2849;
			5'd24:   r = 16'd2731;
			5'd25:   r = 16'd2621;
			5'd26:   r = 16'd2521;
			5'd27:   r = 16'd2427;
			5'd28:   r = 16'd2341;
			5'd29:   r = 16'd2260;
			5'd30:   r = 16'd2185;
			5'd31:   r = 16'd2114;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ src/crs_if.sv @@
// Valid/ready channel interfaces for control points and output samples.
interface crs_point_if #(parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic                          last_point;

	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface crs_sample_if #(parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] sample_x;
	logic signed [COORD_WIDTH-1:0] sample_y;
	logic                          last_sample;

	modport source (output valid, sample_x, sample_y, last_sample, input ready);
	modport sink   (input valid, sample_x, sample_y, last_sample, output ready);
endinterface

@@ src/crs_fifo.sv @@
// Small job queue between the point front end and the sample back end.
module crs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = crs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             pop_valid
);
	import crs_pkg::*;

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;

	assign full      = (cnt_q == CNTW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule

@@ src/crs_front.sv @@
// Front end: takes control points, keeps the window and queues segment jobs.
module crs_front #(
	parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	crs_point_if.sink                                    points,
	input  logic                                         cfg_we,
	input  logic [crs_pkg::CFG_W-1:0]                    cfg_wdata,
	output logic                                         push,
	output logic [crs_pkg::job_width(COORD_WIDTH)-1:0]   push_data,
	input  logic                                         full
);
	import crs_pkg::*;

	localparam int JOB_MAIN  = 0;
	localparam int JOB_TAIL  = 1;
	localparam int JOB_FINAL = 2;

	typedef struct packed {
		logic signed [COORD_WIDTH+2:0] d;
		logic signed [COORD_WIDTH+3:0] c;
		logic signed [COORD_WIDTH:0]   b;
		logic signed [COORD_WIDTH:0]   a;
	} coef_t;

	typedef struct packed {
		coef_t            x;
		coef_t            y;
		logic [CFG_W-1:0] nseg;
		logic             last;
	} job_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	logic [CFG_W-1:0] sps_q;
	logic [1:0]       seen_q;
	logic [1:0]       seen_acc_q;
	logic [2:0]       pend_q;
	coord_t           win_x_q [4];
	coord_t           win_y_q [4];

	logic             accept;
	logic [CFG_W-1:0] sps_clamped;
	coord_t           qx [4];
	coord_t           qy [4];
	job_t             job;

	function automatic coef_t make_coef(input coord_t p0, input coord_t p1,
	                                    input coord_t p2, input coord_t p3);
		logic signed [COORD_WIDTH+3:0] e0, e1, e2, e3, dv, cv;
		coef_t r;
		e0 = (COORD_WIDTH+4)'(p0);
		e1 = (COORD_WIDTH+4)'(p1);
		e2 = (COORD_WIDTH+4)'(p2);
		e3 = (COORD_WIDTH+4)'(p3);
		dv = (e1 <<< 1) + e1 - e0 - ((e2 <<< 1) + e2) + e3;
		cv = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
		r.d = dv[COORD_WIDTH+2:0];
		r.c = cv;
		r.b = (COORD_WIDTH+1)'(e2 - e0);
		r.a = (COORD_WIDTH+1)'(e1 <<< 1);
		return r;
	endfunction

	assign points.ready = (pend_q == '0);
	assign accept       = points.valid && points.ready;
	assign push         = (pend_q != '0) && !full;

	always_comb begin
		if (cfg_wdata < CFG_W'(SAMPLES_MIN)) begin
			sps_clamped = CFG_W'(SAMPLES_MIN);
		end else if (cfg_wdata > CFG_W'(MAX_SAMPLES)) begin
			sps_clamped = CFG_W'(MAX_SAMPLES);
		end else begin
			sps_clamped = cfg_wdata;
		end
	end

	// win[0..3] holds the quad after the shift; the curve window is win[1..3]
	always_comb begin
		if (pend_q[JOB_MAIN]) begin
			qx[0] = (seen_acc_q == 2'd2) ? win_x_q[1] : win_x_q[0];
			qy[0] = (seen_acc_q == 2'd2) ? win_y_q[1] : win_y_q[0];
			qx[1] = win_x_q[1]; qx[2] = win_x_q[2]; qx[3] = win_x_q[3];
			qy[1] = win_y_q[1]; qy[2] = win_y_q[2]; qy[3] = win_y_q[3];
		end else if (pend_q[JOB_TAIL]) begin
			// last segment; a two-point curve's first point is its own predecessor
			qx[0] = (seen_acc_q == 2'd1) ? win_x_q[2] : win_x_q[1];
			qy[0] = (seen_acc_q == 2'd1) ? win_y_q[2] : win_y_q[1];
			qx[1] = win_x_q[2]; qx[2] = win_x_q[3]; qx[3] = win_x_q[3];
			qy[1] = win_y_q[2]; qy[2] = win_y_q[3]; qy[3] = win_y_q[3];
		end else begin
			// end point alone: a flat quad at t = 0 gives it back exactly
			qx[0] = win_x_q[3]; qx[1] = win_x_q[3]; qx[2] = win_x_q[3]; qx[3] = win_x_q[3];
			qy[0] = win_y_q[3]; qy[1] = win_y_q[3]; qy[2] = win_y_q[3]; qy[3] = win_y_q[3];
		end
		job.x    = make_coef(qx[0], qx[1], qx[2], qx[3]);
		job.y    = make_coef(qy[0], qy[1], qy[2], qy[3]);
		job.nseg = sps_q;
		job.last = !pend_q[JOB_MAIN] && !pend_q[JOB_TAIL];
	end

	assign push_data = job;

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				win_x_q[i] <= win_x_q[i+1];
				win_y_q[i] <= win_y_q[i+1];
			end
			win_x_q[3] <= points.point_x;
			win_y_q[3] <= points.point_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q      <= CFG_W'(SAMPLES_RESET);
			seen_q     <= '0;
			seen_acc_q <= '0;
			pend_q     <= '0;
		end else begin
			if (cfg_we) begin
				sps_q <= sps_clamped;
			end
			if (accept) begin
				seen_acc_q         <= seen_q;
				pend_q[JOB_MAIN]   <= (seen_q >= 2'd2);
				pend_q[JOB_TAIL]   <= points.last_point && (seen_q != '0);
				pend_q[JOB_FINAL]  <= points.last_point && (seen_q != '0);
				if (points.last_point) begin
					seen_q <= '0;
				end else if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end else if (push) begin
				pend_q <= pend_q & (pend_q - 3'd1);
			end
		end
	end

endmodule

@@ src/crs_back.sv @@
// Back end: feeds queued jobs to a Horner pipeline, one sample per cycle if not stalled.
module crs_back #(
	parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         job_valid,
	input  logic [crs_pkg::job_width(COORD_WIDTH)-1:0]   job_data,
	output logic                                         job_pop,
	crs_sample_if.source                                 samples
);
	import crs_pkg::*;

	localparam int AW  = COORD_WIDTH + 13;  // accumulator, scaled by 2^8
	localparam int PW1 = COORD_WIDTH + 20;
	localparam int PW  = AW + T_W + 1;
	localparam logic signed [AW-1:0] RND    = AW'(1) <<< FRAC_EXTRA;
	localparam logic signed [AW-1:0] SAT_HI = (AW'(1) <<< (COORD_WIDTH - 1)) - AW'(1);
	localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic signed [COORD_WIDTH+2:0] d;
		logic signed [COORD_WIDTH+3:0] c;
		logic signed [COORD_WIDTH:0]   b;
		logic signed [COORD_WIDTH:0]   a;
	} coef_t;

	typedef struct packed {
		coef_t            x;
		coef_t            y;
		logic [CFG_W-1:0] nseg;
		logic             last;
	} job_t;

	job_t                  job;
	logic                  en;
	logic                  issue;
	logic                  done;
	logic [CFG_W-1:0]      n_issue;
	logic [CFG_W+T_W-1:0]  t_full;
	logic [CFG_W-1:0]      j_q;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                  last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7, last_s8;
	logic [T_W-1:0]        t_s1, t_s2, t_s3, t_s4, t_s5;
	logic signed [T_W:0]   ts1, ts3, ts5;

	logic signed [COORD_WIDTH+2:0] d_s1 [2];
	logic signed [COORD_WIDTH+3:0] c_s1 [2];
	logic signed [COORD_WIDTH+3:0] c_s2 [2];
	logic signed [COORD_WIDTH:0]   b_s1 [2];
	logic signed [COORD_WIDTH:0]   b_s2 [2];
	logic signed [COORD_WIDTH:0]   b_s3 [2];
	logic signed [COORD_WIDTH:0]   b_s4 [2];
	logic signed [COORD_WIDTH:0]   a_s1 [2];
	logic signed [COORD_WIDTH:0]   a_s2 [2];
	logic signed [COORD_WIDTH:0]   a_s3 [2];
	logic signed [COORD_WIDTH:0]   a_s4 [2];
	logic signed [COORD_WIDTH:0]   a_s5 [2];
	logic signed [COORD_WIDTH:0]   a_s6 [2];
	logic signed [PW1-1:0]         prod_s2 [2];
	logic signed [AW-1:0]          acc_s3 [2];
	logic signed [PW-1:0]          prod_s4 [2];
	logic signed [AW-1:0]          acc_s5 [2];
	logic signed [PW-1:0]          prod_s6 [2];
	logic signed [AW-1:0]          acc_s7 [2];
	logic signed [AW-1:0]          rnd [2];
	logic signed [COORD_WIDTH-1:0] sat [2];
	logic signed [COORD_WIDTH-1:0] out_s8 [2];

	assign job     = job_t'(job_data);
	assign en      = !v_s8 || samples.ready;
	assign issue   = job_valid && en;
	assign n_issue = job.last ? CFG_W'(1) : job.nseg;
	assign done    = (j_q == n_issue - CFG_W'(1));
	assign job_pop = issue && done;
	assign t_full  = (CFG_W+T_W)'(j_q) * (CFG_W+T_W)'(recip(job.nseg));

	assign ts1 = $signed({1'b0, t_s1});
	assign ts3 = $signed({1'b0, t_s3});
	assign ts5 = $signed({1'b0, t_s5});

	// round half up to Q16.8, then clamp to the coordinate range
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rnd[i] = (acc_s7[i] + RND) >>> (FRAC_EXTRA + 1);
			if (rnd[i] > SAT_HI) begin
				sat[i] = SAT_HI[COORD_WIDTH-1:0];
			end else if (rnd[i] < SAT_LO) begin
				sat[i] = SAT_LO[COORD_WIDTH-1:0];
			end else begin
				sat[i] = rnd[i][COORD_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_full[T_W-1:0];
			last_s1 <= job.last;
			d_s1[0] <= job.x.d; c_s1[0] <= job.x.c; b_s1[0] <= job.x.b; a_s1[0] <= job.x.a;
			d_s1[1] <= job.y.d; c_s1[1] <= job.y.c; b_s1[1] <= job.y.b; a_s1[1] <= job.y.a;
			t_s2 <= t_s1; t_s3 <= t_s2; t_s4 <= t_s3; t_s5 <= t_s4;
			last_s2 <= last_s1; last_s3 <= last_s2; last_s4 <= last_s3;
			last_s5 <= last_s4; last_s6 <= last_s5; last_s7 <= last_s6;
			last_s8 <= last_s7;
			for (int i = 0; i < 2; i++) begin
				// d*256*t/2^16 folds into one shift by 8
				prod_s2[i] <= PW1'(d_s1[i]) * PW1'(ts1);
				c_s2[i]    <= c_s1[i];
				b_s2[i]    <= b_s1[i];
				a_s2[i]    <= a_s1[i];
				acc_s3[i]  <= AW'(prod_s2[i] >>> (T_FRAC - FRAC_EXTRA))
				            + (AW'(c_s2[i]) <<< FRAC_EXTRA);
				b_s3[i]    <= b_s2[i];
				a_s3[i]    <= a_s2[i];
				prod_s4[i] <= PW'(acc_s3[i]) * PW'(ts3);
				b_s4[i]    <= b_s3[i];
				a_s4[i]    <= a_s3[i];
				acc_s5[i]  <= AW'(prod_s4[i] >>> T_FRAC) + (AW'(b_s4[i]) <<< FRAC_EXTRA);
				a_s5[i]    <= a_s4[i];
				prod_s6[i] <= PW'(acc_s5[i]) * PW'(ts5);
				a_s6[i]    <= a_s5[i];
				acc_s7[i]  <= AW'(prod_s6[i] >>> T_FRAC) + (AW'(a_s6[i]) <<< FRAC_EXTRA);
				out_s8[i]  <= sat[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q  <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (issue) begin
				j_q <= done ? '0 : j_q + CFG_W'(1);
			end
			if (en) begin
				v_s1 <= job_valid;
				v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
				v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			end
		end
	end

	assign samples.valid       = v_s8;
	assign samples.sample_x    = out_s8[0];
	assign samples.sample_y    = out_s8[1];
	assign samples.last_sample = last_s8;

endmodule

@@ src/catmull_rom_spline_sampler.sv @@
// Top level of the uniform Catmull-Rom spline sampler.
//
//   word        direction  contents
//   points      in         point_x, point_y (signed Q16.8), last_point
//   samples     out        sample_x, sample_y (signed Q16.8), last_sample
//   cfg_we/wd   in         samples_per_segment, clamped to 2..31 on write
//
// The back end issues one sample per cycle into the Horner pipeline while the
// output is not stalled; a point that closes a segment costs samples_per_segment
// samples, and a curve's last point up to two segments plus one. The front end
// takes a point only when no job is pending, then pushes its jobs; pushes stall
// only when the job queue is full. Output stalls freeze the whole pipeline.
// Reset clears the queue, the pipeline valids and the point count.
module catmull_rom_spline_sampler #(
	parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH,
	parameter int QUEUE_DEPTH = crs_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	crs_point_if.sink                 points,
	crs_sample_if.source              samples,
	input  logic                      cfg_we,
	input  logic [crs_pkg::CFG_W-1:0] cfg_wdata
);
	import crs_pkg::*;

	localparam int JW = job_width(COORD_WIDTH);

	logic          push;
	logic [JW-1:0] push_data;
	logic          full;
	logic          job_pop;
	logic [JW-1:0] job_data;
	logic          job_valid;

	crs_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.points    (points),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	crs_fifo #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (job_pop),
		.pop_data  (job_data),
		.pop_valid (job_valid)
	);

	crs_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_data  (job_data),
		.job_pop   (job_pop),
		.samples   (samples)
	);

endmodule

@@ src/crs_checker.sv @@
// Port-level checks for the spline sampler, bound to the top level.
module crs_checker #(
	parameter int COORD_WIDTH = crs_pkg::COORD_WIDTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_WIDTH-1:0] out_x,
	input logic signed [COORD_WIDTH-1:0] out_y,
	input logic                          out_last
);
	import crs_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_last))
		else $error("sample word changed while stalled");

	// input side only closes after taking a point
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("point ready dropped without an accepted point");

	// the next curve needs at least one segment before its end point
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !(out_valid && out_last))
		else $error("two end samples back to back");

endmodule

bind catmull_rom_spline_sampler crs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_crs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.out_valid (samples.valid),
	.out_ready (samples.ready),
	.out_x     (samples.sample_x),
	.out_y     (samples.sample_y),
	.out_last  (samples.last_sample)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the Catmull-Rom spline sampler: random points in, samples checked.
`timescale 1ns / 100ps

module tb_top;

	import crs_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam longint COORD_HI = (64'sd1 <<< (W - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;
	localparam logic signed [W-1:0] COORD_MAX = COORD_HI[W-1:0];
	localparam logic signed [W-1:0] COORD_MIN = COORD_LO[W-1:0];
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_REPORTS = 10;
	localparam int SRC_IDLE_A = 27;
	localparam int SINK_IDLE_A = 55;
	localparam int NO_IDLE = 0;

	typedef struct packed {
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic                last;
	} spline_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	crs_point_if  point_ch ();
	crs_sample_if sample_ch ();

	catmull_rom_spline_sampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.points    (point_ch),
		.samples   (sample_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	spline_word_t point_feed[$];
	spline_word_t expected_samples[$];
	spline_word_t point_in_flight;
	int src_idle_pct = SRC_IDLE_A;
	int sink_idle_pct = SINK_IDLE_A;
	int sample_errors = 0;
	int stall_cycles = 0;

	// predictor state: last three control points, index 2 newest
	longint curve_x[3];
	longint curve_y[3];
	int curve_pts = 0;
	int seg_samples = SAMPLES_RESET;

	function automatic logic signed [W-1:0] spline_axis(longint p0, longint p1, longint p2,
			longint p3, longint t);
		longint a, b, c, d, acc, r;
		a = 2 * p1;
		b = p2 - p0;
		c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		d = -p0 + 3 * p1 - 3 * p2 + p3;
		// Horner on coefficients scaled by 2^8, each t product floored
		acc = d * 256;
		acc = ((acc * t) >>> T_FRAC) + c * 256;
		acc = ((acc * t) >>> T_FRAC) + b * 256;
		acc = ((acc * t) >>> T_FRAC) + a * 256;
		r = (acc + 256) >>> (FRAC_EXTRA + 1);
		if (r > COORD_HI)
			r = COORD_HI;
		if (r < COORD_LO)
			r = COORD_LO;
		return r[W-1:0];
	endfunction

	function automatic void push_segment(longint x0, longint x1, longint x2, longint x3,
			longint y0, longint y1, longint y2, longint y3);
		longint t_step;
		spline_word_t s;
		t_step = (65536 + seg_samples / 2) / seg_samples;
		for (int j = 0; j < seg_samples; j++) begin
			s.x = spline_axis(x0, x1, x2, x3, j * t_step);
			s.y = spline_axis(y0, y1, y2, y3, j * t_step);
			s.last = 1'b0;
			expected_samples.push_back(s);
		end
	endfunction

	function automatic void predict_samples(spline_word_t pt);
		longint nx, ny;
		int seen;
		spline_word_t s;
		nx = $signed(pt.x);
		ny = $signed(pt.y);
		seen = curve_pts;
		if (seen == 1) begin
			if (pt.last)
				push_segment(curve_x[2], curve_x[2], nx, nx, curve_y[2], curve_y[2], ny, ny);
		end else if (seen >= 2) begin
			// first segment uses its start point as its own predecessor
			push_segment(seen == 2 ? curve_x[1] : curve_x[0], curve_x[1], curve_x[2], nx,
				seen == 2 ? curve_y[1] : curve_y[0], curve_y[1], curve_y[2], ny);
			if (pt.last)
				push_segment(curve_x[1], curve_x[2], nx, nx, curve_y[1], curve_y[2], ny, ny);
		end
		if (pt.last && seen >= 1) begin
			s.x = pt.x;
			s.y = pt.y;
			s.last = 1'b1;
			expected_samples.push_back(s);
		end
		curve_x[0] = curve_x[1];
		curve_x[1] = curve_x[2];
		curve_x[2] = nx;
		curve_y[0] = curve_y[1];
		curve_y[1] = curve_y[2];
		curve_y[2] = ny;
		if (pt.last)
			curve_pts = 0;
		else if (seen < 3)
			curve_pts = seen + 1;
	endfunction

	// point driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_ch.valid <= 1'b0;
			point_ch.point_x <= '0;
			point_ch.point_y <= '0;
			point_ch.last_point <= 1'b0;
		end else begin
			if (point_ch.valid && point_ch.ready)
				predict_samples(point_in_flight);
			if (!point_ch.valid || point_ch.ready) begin
				if (point_feed.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					point_in_flight = point_feed.pop_front();
					point_ch.valid <= 1'b1;
					point_ch.point_x <= point_in_flight.x;
					point_ch.point_y <= point_in_flight.y;
					point_ch.last_point <= point_in_flight.last;
				end else begin
					point_ch.valid <= 1'b0;
				end
			end
		end
	end

	// sample monitor and checker
	always @(posedge clk or negedge arst_n) begin : sample_mon
		spline_word_t got, want;
		if (!arst_n) begin
			sample_ch.ready <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				got.x = sample_ch.sample_x;
				got.y = sample_ch.sample_y;
				got.last = sample_ch.last_sample;
				if (expected_samples.size() == 0) begin
					sample_errors++;
					if (sample_errors <= MAX_REPORTS)
						$display("unexpected sample word x=%0d y=%0d last=%0b",
							got.x, got.y, got.last);
				end else begin
					want = expected_samples.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
						sample_errors++;
						if (sample_errors <= MAX_REPORTS)
							$display("sample mismatch: want x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
								want.x, want.y, want.last, got.x, got.y, got.last);
					end
				end
			end
			sample_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (point_ch.valid && point_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[catmull_rom_spline_sampler] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic signed [W-1:0] rand_coord();
		int v;
		case ($urandom_range(9))
			0: v = $urandom;
			1: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
			default: v = int'($urandom_range(131072)) - 65536;
		endcase
		return v[W-1:0];
	endfunction

	task automatic push_point(logic signed [W-1:0] x, logic signed [W-1:0] y, logic last);
		spline_word_t p;
		p.x = x;
		p.y = y;
		p.last = last;
		point_feed.push_back(p);
	endtask

	task automatic push_curve(int n_pts);
		for (int i = 0; i < n_pts; i++)
			push_point(rand_coord(), rand_coord(), i == n_pts - 1);
	endtask

	// wait until no point is pending and every sample has come, then let the pipe empty
	task automatic settle();
		do
			@(negedge clk);
		while (point_feed.size() != 0 || point_ch.valid || expected_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_samples(logic [CFG_W-1:0] v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		seg_samples = (v < SAMPLES_MIN) ? SAMPLES_MIN : v;
	endtask

	task automatic run_phase(logic [CFG_W-1:0] cfg, int src_pct, int snk_pct, int n_items);
		int made, n;
		set_samples(cfg);
		src_idle_pct = src_pct;
		sink_idle_pct = snk_pct;
		made = 0;
		while (made < n_items) begin
			n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 7);
			if (n > n_items - made)
				n = n_items - made;
			push_curve(n);
			made += n;
		end
	endtask

	initial begin
		point_ch.valid = 1'b0;
		point_ch.point_x = '0;
		point_ch.point_y = '0;
		point_ch.last_point = 1'b0;
		sample_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset setting, lone point, two-point curve at the extremes
		push_point(24'sd25600, -24'sd25600, 1'b1);
		push_point('0, '0, 1'b0);
		push_point(COORD_MAX, COORD_MIN, 1'b1);
		// write below the minimum, then a saturating three-point zigzag
		set_samples(5'd0);
		push_point(COORD_MIN, COORD_MAX, 1'b0);
		push_point(COORD_MAX, COORD_MIN, 1'b0);
		push_point(COORD_MIN, COORD_MAX, 1'b1);
		// longer curve so the point count saturates, then a lone point after it
		push_point(24'sd256, 24'sd512, 1'b0);
		push_point(-24'sd768, 24'sd1024, 1'b0);
		push_point(24'sd4096, -24'sd2048, 1'b0);
		push_point('0, '0, 1'b0);
		push_point(24'sd12800, -24'sd12800, 1'b1);
		push_point(-24'sd1, 24'sd1, 1'b1);
		set_samples(5'd31);
		push_point(24'sd1, -24'sd1, 1'b0);
		push_point(-24'sd2, 24'sd2, 1'b1);
		push_point(COORD_MAX, COORD_MAX, 1'b0);
		push_point(COORD_MIN, COORD_MIN, 1'b0);
		push_point(24'sd300, -24'sd300, 1'b0);
		push_point(COORD_MAX, COORD_MIN, 1'b1);

		run_phase(5'd1, SRC_IDLE_A, SINK_IDLE_A, 41);
		run_phase(5'($urandom_range(3, 8)), SRC_IDLE_A, SINK_IDLE_A, 41);
		run_phase(5'd2, SINK_IDLE_A, SRC_IDLE_A, 40);
		run_phase(5'($urandom_range(0, 31)), SINK_IDLE_A, SRC_IDLE_A, 40);
		run_phase(5'd31, NO_IDLE, NO_IDLE, 15);
		run_phase(5'($urandom_range(4, 10)), NO_IDLE, NO_IDLE, 35);

		settle();
		if (sample_errors == 0 && expected_samples.size() == 0)
			$display("[catmull_rom_spline_sampler] OK");
		else
			$display("[catmull_rom_spline_sampler] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
src/crs_pkg.sv
src/crs_if.sv
src/crs_fifo.sv
src/crs_front.sv
src/crs_back.sv
src/catmull_rom_spline_sampler.sv
src/crs_checker.sv
tb/tb_top.sv
